FILE: src/closest_point_on_triangle_assert.svh
// Assertion macros shared by the closest-point RTL.
// Needs no other file; define ASSERT_OFF to compile the checks away.
`ifndef CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`define CLOSEST_POINT_ON_TRIANGLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define CPT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPT_ASSERT(lbl, clk, rst, prop, msg)
`define CPT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: src/cpt_pkg.sv
// Shared constants of the closest-point-on-triangle pipeline.
// No dependencies; cpt_mul, cpt_region and the top level import it.
package cpt_pkg;

   localparam int COORD_WIDTH_DEF = 32;   // Q16.16 coordinates by default
   localparam int LIMB_WIDTH      = 32;   // width of one partial-product limb
   localparam int MUL_LAT         = 4;    // register stages in cpt_mul
   localparam int REGION_LAT      = 2;    // register stages in cpt_region

   // Index of each dot product in the dot array.
   localparam int DOT_A = 0;
   localparam int DOT_B = 1;
   localparam int DOT_C = 2;
   localparam int DOT_D = 3;
   localparam int DOT_E = 4;
   localparam int DOT_NUM = 5;

endpackage

FILE: src/cpt_dly.sv
// Enabled shift register that carries side data alongside the pipeline.
// Depends on nothing else.
module cpt_dly #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] sr_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         sr_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            sr_ff[i] <= sr_ff[i-1];
         end
      end
   end

   assign dout = sr_ff[DEPTH-1];

endmodule

FILE: src/cpt_mul.sv
// Pipelined signed multiplier built from 32x32 limb products.
// Depends on cpt_pkg (LIMB_WIDTH); it has MUL_LAT register stages.
module cpt_mul import cpt_pkg::*; #(
   parameter int AW = 33,
   parameter int BW = 33
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [AW-1:0]    op_a,
   input  logic signed [BW-1:0]    op_b,
   output logic signed [AW+BW-1:0] prod
);

   localparam int NA = (AW + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int NB = (BW + LIMB_WIDTH - 1) / LIMB_WIDTH;
   localparam int PW = AW + BW;
   localparam int RW = (NB + 1) * LIMB_WIDTH;
   localparam int TW = (NA + NB) * LIMB_WIDTH;

   logic [NA*LIMB_WIDTH-1:0] ua_in, ua_ff;
   logic [NB*LIMB_WIDTH-1:0] ub_in, ub_ff;
   logic                     neg1_ff, neg2_ff, neg3_ff;
   logic [2*LIMB_WIDTH-1:0]  pp_ff [NA][NB];
   logic [RW-1:0]            row_in [NA];
   logic [RW-1:0]            row_ff [NA];
   logic [TW-1:0]            sum_in;
   logic signed [PW-1:0]     prod_ff;

   // Work on magnitudes; the sign is applied after the final sum.
   always_comb begin
      ua_in = op_a[AW-1] ? (NA*LIMB_WIDTH)'(unsigned'(-op_a))
                         : (NA*LIMB_WIDTH)'(unsigned'(op_a));
      ub_in = op_b[BW-1] ? (NB*LIMB_WIDTH)'(unsigned'(-op_b))
                         : (NB*LIMB_WIDTH)'(unsigned'(op_b));
   end

   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (RW'(pp_ff[i][j]) << (j * LIMB_WIDTH));
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int i = 0; i < NA; i++) begin
         sum_in = sum_in + (TW'(row_ff[i]) << (i * LIMB_WIDTH));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         neg1_ff <= op_a[AW-1] ^ op_b[BW-1];
         for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
               pp_ff[i][j] <= ua_ff[i*LIMB_WIDTH +: LIMB_WIDTH]
                              * ub_ff[j*LIMB_WIDTH +: LIMB_WIDTH];
            end
         end
         neg2_ff <= neg1_ff;
         row_ff  <= row_in;
         neg3_ff <= neg2_ff;
         prod_ff <= neg3_ff ? signed'(PW'(-sum_in)) : signed'(PW'(sum_in));
      end
   end

   assign prod = prod_ff;

endmodule

FILE: src/cpt_region.sv
// Region classification: clamps the parameters s and t onto the triangle.
// Depends on cpt_pkg; two register stages (REGION_LAT).
module cpt_region import cpt_pkg::*; #(
   parameter int DW = 68,
   parameter int SW = 137
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [DW-1:0] dot_a,
   input  logic signed [DW-1:0] dot_b,
   input  logic signed [DW-1:0] dot_c,
   input  logic signed [DW-1:0] dot_d,
   input  logic signed [DW-1:0] dot_e,
   input  logic signed [SW-1:0] det,
   input  logic signed [SW-1:0] s,
   input  logic signed [SW-1:0] t,
   output logic signed [SW-1:0] sn,
   output logic signed [SW-1:0] tn,
   output logic signed [SW-1:0] den,
   output logic                 degen
);

   localparam int XW = DW + 2;

   logic signed [SW:0]   st;
   logic signed [XW-1:0] ce, bd, ad, be;
   logic signed [XW-1:0] n1_ff, n2_ff, m_ff, ne_ff, nd_ff, a_ff, c_ff;
   logic signed [SW-1:0] s_ff, t_ff, det_ff;
   logic le_ff, sneg_ff, tneg_ff, eneg_ff, dneg_ff, degen1_ff, ce_np_ff, ad_np_ff;
   logic ge1, ge2, gec, gea, n1pos, n2pos;
   logic signed [SW-1:0] sn_in, tn_in, den_in, sn_ff, tn_ff, den_ff;
   logic                 degen_ff;

   // First stage: sums and differences of the dot products.
   always_comb begin
      st = (SW+1)'(s) + (SW+1)'(t);
      ce = XW'(dot_c) + XW'(dot_e);
      bd = XW'(dot_b) + XW'(dot_d);
      ad = XW'(dot_a) + XW'(dot_d);
      be = XW'(dot_b) + XW'(dot_e);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         le_ff     <= st <= (SW+1)'(det);
         sneg_ff   <= s[SW-1];
         tneg_ff   <= t[SW-1];
         eneg_ff   <= dot_e[DW-1];
         dneg_ff   <= dot_d[DW-1];
         degen1_ff <= det[SW-1] || (det == '0);
         ce_np_ff  <= ce[XW-1] || (ce == '0);
         ad_np_ff  <= ad[XW-1] || (ad == '0);
         n1_ff     <= ce - bd;
         n2_ff     <= ad - be;
         m_ff      <= XW'(dot_a) + XW'(dot_c) - (XW'(dot_b) <<< 1);
         ne_ff     <= -XW'(dot_e);
         nd_ff     <= -XW'(dot_d);
         a_ff      <= XW'(dot_a);
         c_ff      <= XW'(dot_c);
         s_ff      <= s;
         t_ff      <= t;
         det_ff    <= det;
      end
   end

   // Second stage: clamps and the choice of fractions.
   always_comb begin
      ge1   = n1_ff >= m_ff;
      ge2   = n2_ff >= m_ff;
      gec   = ne_ff >= c_ff;
      gea   = nd_ff >= a_ff;
      n1pos = !n1_ff[XW-1] && (n1_ff != '0);
      n2pos = !n2_ff[XW-1] && (n2_ff != '0);
      sn_in  = '0;
      tn_in  = '0;
      den_in = SW'(1);
      priority if (degen1_ff) begin
         sn_in = '0;
      end else if (le_ff) begin
         if (sneg_ff && tneg_ff && !eneg_ff && dneg_ff) begin
            sn_in  = gea ? SW'(1) : SW'(nd_ff);
            den_in = gea ? SW'(1) : SW'(a_ff);
         end else if (sneg_ff && eneg_ff) begin
            tn_in  = gec ? SW'(1) : SW'(ne_ff);
            den_in = gec ? SW'(1) : SW'(c_ff);
         end else if (!sneg_ff && tneg_ff && dneg_ff) begin
            sn_in  = gea ? SW'(1) : SW'(nd_ff);
            den_in = gea ? SW'(1) : SW'(a_ff);
         end else if (!sneg_ff && !tneg_ff) begin
            sn_in  = s_ff;
            tn_in  = t_ff;
            den_in = det_ff;
         end
      end else if (sneg_ff) begin
         priority if (n1pos) begin
            sn_in  = ge1 ? SW'(1) : SW'(n1_ff);
            tn_in  = ge1 ? '0 : SW'(m_ff - n1_ff);
            den_in = ge1 ? SW'(1) : SW'(m_ff);
         end else if (ce_np_ff) begin
            tn_in = SW'(1);
         end else if (eneg_ff) begin
            tn_in  = SW'(ne_ff);
            den_in = SW'(c_ff);
         end else begin
            // No clamp applies: the point maps onto vertex A.
            tn_in = '0;
         end
      end else if (tneg_ff) begin
         priority if (n2pos) begin
            tn_in  = ge2 ? SW'(1) : SW'(n2_ff);
            sn_in  = ge2 ? '0 : SW'(m_ff - n2_ff);
            den_in = ge2 ? SW'(1) : SW'(m_ff);
         end else if (ad_np_ff) begin
            sn_in = SW'(1);
         end else if (dneg_ff) begin
            sn_in  = SW'(nd_ff);
            den_in = SW'(a_ff);
         end else begin
            // No clamp applies: the point maps onto vertex A.
            sn_in = '0;
         end
      end else begin
         priority if (!n1pos) begin
            tn_in = SW'(1);
         end else begin
            sn_in  = ge1 ? SW'(1) : SW'(n1_ff);
            tn_in  = ge1 ? '0 : SW'(m_ff - n1_ff);
            den_in = ge1 ? SW'(1) : SW'(m_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sn_ff    <= sn_in;
         tn_ff    <= tn_in;
         den_ff   <= den_in;
         degen_ff <= degen1_ff;
      end
   end

   assign sn    = sn_ff;
   assign tn    = tn_ff;
   assign den   = den_ff;
   assign degen = degen_ff;

endmodule

FILE: src/cpt_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing else; it has QB register stages.
module cpt_div #(
   parameter int NB = 173,
   parameter int DB = 138,
   parameter int QB = 34
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NB-1:0] numer,
   input  logic [DB-1:0] dvs,
   input  logic          neg,
   output logic [QB-1:0] q_mag,
   output logic          rem_nz,
   output logic          neg_out
);

   localparam int CW = (NB > DB + QB) ? NB : DB + QB;

   logic [CW-1:0] r_ff [QB];
   logic [QB-1:0] q_ff [QB];
   logic [DB-1:0] d_ff [QB];
   logic          n_ff [QB];

   for (genvar k = 0; k < QB; k++) begin : g_stage
      logic [CW-1:0] r_prev, shd;
      logic [QB-1:0] q_prev;
      logic [DB-1:0] d_prev;
      logic          n_prev, ge;
      if (k == 0) begin : g_first
         assign r_prev = CW'(numer);
         assign q_prev = '0;
         assign d_prev = dvs;
         assign n_prev = neg;
      end else begin : g_next
         assign r_prev = r_ff[k-1];
         assign q_prev = q_ff[k-1];
         assign d_prev = d_ff[k-1];
         assign n_prev = n_ff[k-1];
      end
      assign shd = CW'(d_prev) << (QB - 1 - k);
      assign ge  = r_prev >= shd;
      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[k] <= ge ? r_prev - shd : r_prev;
            q_ff[k] <= q_prev | (QB'(ge) << (QB - 1 - k));
            d_ff[k] <= d_prev;
            n_ff[k] <= n_prev;
         end
      end
   end

   assign q_mag   = q_ff[QB-1];
   assign rem_nz  = |r_ff[QB-1];
   assign neg_out = n_ff[QB-1];

endmodule

FILE: src/closest_point_on_triangle.sv
// Closest point on a 3D triangle: top level of a fully pipelined unit.
// The request channel (req_*) carries one item: the query point P and the
// vertices A, B, C, twelve signed fixed-point coordinates packed in
// req_tdata. The response channel (rsp_*) returns one item per request, the
// point of the triangle nearest to P, in the same format and order.
// Throughput is one item per clock cycle while the receiver does not hold
// rsp_tready low with a result waiting. The limb-split wide multipliers and
// the restoring divider, one quotient bit per stage, make up most of the
// pipeline.
// A degenerate triangle (determinant zero or negative) returns vertex A.
// Reset clears every valid bit, so no stale item appears on rsp_*.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops; no item is lost or repeated, and
// empty stages ahead of the output still fill while rsp_tvalid is low.
// Depends on cpt_pkg, cpt_dly, cpt_mul, cpt_region, cpt_div and the
// assertion macro header.
`include "closest_point_on_triangle_assert.svh"
module closest_point_on_triangle import cpt_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   localparam int REQ_TDW = ((12 * COORD_WIDTH + 7) / 8) * 8,
   localparam int RSP_TDW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // point_x, point_y, point_z, vertex_a_x, vertex_a_y, vertex_a_z,
   // vertex_b_x, vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z
   input  logic [REQ_TDW-1:0] req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // closest_x, closest_y, closest_z
   output logic [RSP_TDW-1:0] rsp_tdata
);

   localparam int W   = COORD_WIDTH;
   localparam int EW  = W + 1;           // edge and offset vectors
   localparam int PW  = 2 * EW;          // one coordinate product
   localparam int DW  = PW + 2;          // dot products
   localparam int MW  = 2 * DW;          // product of two dot products
   localparam int SW  = MW + 1;          // det, s, t and the fractions
   localparam int NW  = EW + SW + 1;     // E0*sn + E1*tn
   localparam int N2W = NW + 2;          // 2*num + den
   localparam int VW  = SW + 1;          // divisor 2*den
   localparam int QB  = W + 2;           // quotient magnitude bits
   localparam int GW  = 3 * W + 6 * EW;  // A, E0, E1 packed
   localparam int LAT = 3 + MUL_LAT + 1 + REGION_LAT + MUL_LAT + 1 + QB + 1;
   localparam logic [QB-1:0] QMAX = QB'(1) << W;

   logic             en;
   logic [LAT-1:0]   v_ff;

   // Stage 1: edges and the offset A - P.
   logic signed [EW-1:0] e0_ff [3];
   logic signed [EW-1:0] e1_ff [3];
   logic signed [EW-1:0] dv_ff [3];
   logic signed [W-1:0]  va_ff [3];
   // Stage 2: coordinate products; stage 3: dot products.
   logic signed [PW-1:0] pr_ff [DOT_NUM][3];
   logic signed [DW-1:0] dot_ff [DOT_NUM];
   logic [GW-1:0]        geo_in, geo_out;
   logic [DOT_NUM*DW-1:0] dots_in, dots_out;
   logic signed [MW-1:0] ac, bb, be, cd, bd, ae;
   logic signed [SW-1:0] det_ff, s_ff, t_ff;
   logic signed [SW-1:0] sn, tn, den, den_d;
   logic                 degen;
   logic signed [W-1:0]  va_g [3];
   logic signed [EW-1:0] e0_g [3];
   logic signed [EW-1:0] e1_g [3];
   logic signed [EW+SW-1:0] p0 [3];
   logic signed [EW+SW-1:0] p1 [3];
   logic [N2W-1:0]       mag_ff [3];
   logic                 neg_ff [3];
   logic [VW-1:0]        dvs_ff;
   logic [3*W:0]         tail_in, tail_out;
   logic [QB-1:0]        qmag [3];
   logic                 rnz [3];
   logic                 qneg [3];
   logic signed [W-1:0]  va_t [3];
   logic                 degen_t;
   logic [W-1:0]         out_ff [3];

   assign en         = !v_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = v_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            va_ff[k] <= signed'(req_tdata[(3+k)*W +: W]);
            e0_ff[k] <= EW'(signed'(req_tdata[(6+k)*W +: W]))
                        - EW'(signed'(req_tdata[(3+k)*W +: W]));
            e1_ff[k] <= EW'(signed'(req_tdata[(9+k)*W +: W]))
                        - EW'(signed'(req_tdata[(3+k)*W +: W]));
            dv_ff[k] <= EW'(signed'(req_tdata[(3+k)*W +: W]))
                        - EW'(signed'(req_tdata[k*W +: W]));
            pr_ff[DOT_A][k] <= PW'(e0_ff[k]) * PW'(e0_ff[k]);
            pr_ff[DOT_B][k] <= PW'(e0_ff[k]) * PW'(e1_ff[k]);
            pr_ff[DOT_C][k] <= PW'(e1_ff[k]) * PW'(e1_ff[k]);
            pr_ff[DOT_D][k] <= PW'(e0_ff[k]) * PW'(dv_ff[k]);
            pr_ff[DOT_E][k] <= PW'(e1_ff[k]) * PW'(dv_ff[k]);
         end
         for (int i = 0; i < DOT_NUM; i++) begin
            dot_ff[i] <= DW'(pr_ff[i][0]) + DW'(pr_ff[i][1]) + DW'(pr_ff[i][2]);
         end
      end
   end

   // Geometry rides along until the final multiply.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         geo_in[k*W +: W]               = va_ff[k];
         geo_in[3*W + k*EW +: EW]       = e0_ff[k];
         geo_in[3*W + (3+k)*EW +: EW]   = e1_ff[k];
         va_g[k] = signed'(geo_out[k*W +: W]);
         e0_g[k] = signed'(geo_out[3*W + k*EW +: EW]);
         e1_g[k] = signed'(geo_out[3*W + (3+k)*EW +: EW]);
      end
      for (int i = 0; i < DOT_NUM; i++) begin
         dots_in[i*DW +: DW] = dot_ff[i];
      end
   end

   cpt_dly #(.WIDTH(GW), .DEPTH(2 + MUL_LAT + 1 + REGION_LAT)) u_geo_dly (
      .clock(clock), .en(en), .din(geo_in), .dout(geo_out));

   cpt_dly #(.WIDTH(DOT_NUM*DW), .DEPTH(MUL_LAT + 1)) u_dot_dly (
      .clock(clock), .en(en), .din(dots_in), .dout(dots_out));

   // Determinant and unnormalized parameters.
   cpt_mul #(.AW(DW), .BW(DW)) u_mul_ac (.clock(clock), .en(en),
      .op_a(dot_ff[DOT_A]), .op_b(dot_ff[DOT_C]), .prod(ac));
   cpt_mul #(.AW(DW), .BW(DW)) u_mul_bb (.clock(clock), .en(en),
      .op_a(dot_ff[DOT_B]), .op_b(dot_ff[DOT_B]), .prod(bb));
   cpt_mul #(.AW(DW), .BW(DW)) u_mul_be (.clock(clock), .en(en),
      .op_a(dot_ff[DOT_B]), .op_b(dot_ff[DOT_E]), .prod(be));
   cpt_mul #(.AW(DW), .BW(DW)) u_mul_cd (.clock(clock), .en(en),
      .op_a(dot_ff[DOT_C]), .op_b(dot_ff[DOT_D]), .prod(cd));
   cpt_mul #(.AW(DW), .BW(DW)) u_mul_bd (.clock(clock), .en(en),
      .op_a(dot_ff[DOT_B]), .op_b(dot_ff[DOT_D]), .prod(bd));
   cpt_mul #(.AW(DW), .BW(DW)) u_mul_ae (.clock(clock), .en(en),
      .op_a(dot_ff[DOT_A]), .op_b(dot_ff[DOT_E]), .prod(ae));

   always_ff @(posedge clock) begin
      if (en) begin
         det_ff <= SW'(ac) - SW'(bb);
         s_ff   <= SW'(be) - SW'(cd);
         t_ff   <= SW'(bd) - SW'(ae);
      end
   end

   cpt_region #(.DW(DW), .SW(SW)) u_region (
      .clock(clock), .en(en),
      .dot_a(signed'(dots_out[DOT_A*DW +: DW])),
      .dot_b(signed'(dots_out[DOT_B*DW +: DW])),
      .dot_c(signed'(dots_out[DOT_C*DW +: DW])),
      .dot_d(signed'(dots_out[DOT_D*DW +: DW])),
      .dot_e(signed'(dots_out[DOT_E*DW +: DW])),
      .det(det_ff), .s(s_ff), .t(t_ff),
      .sn(sn), .tn(tn), .den(den), .degen(degen));

   // Numerators of the closest point relative to A.
   for (genvar k = 0; k < 3; k++) begin : g_axis
      cpt_mul #(.AW(EW), .BW(SW)) u_mul_s (.clock(clock), .en(en),
         .op_a(e0_g[k]), .op_b(sn), .prod(p0[k]));
      cpt_mul #(.AW(EW), .BW(SW)) u_mul_t (.clock(clock), .en(en),
         .op_a(e1_g[k]), .op_b(tn), .prod(p1[k]));
      cpt_div #(.NB(N2W), .DB(VW), .QB(QB)) u_div (.clock(clock), .en(en),
         .numer(mag_ff[k]), .dvs(dvs_ff), .neg(neg_ff[k]),
         .q_mag(qmag[k]), .rem_nz(rnz[k]), .neg_out(qneg[k]));
   end

   cpt_dly #(.WIDTH(SW), .DEPTH(MUL_LAT)) u_den_dly (
      .clock(clock), .en(en), .din(den), .dout(den_d));

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         tail_in[k*W +: W] = va_g[k];
         va_t[k] = signed'(tail_out[k*W +: W]);
      end
      tail_in[3*W] = degen;
      degen_t      = tail_out[3*W];
   end

   cpt_dly #(.WIDTH(3*W + 1), .DEPTH(MUL_LAT + 1 + QB)) u_tail_dly (
      .clock(clock), .en(en), .din(tail_in), .dout(tail_out));

   // Round to nearest with halves upward: floor((2N + den) / (2 den)).
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            logic signed [N2W-1:0] n2;
            n2 = (N2W'(p0[k]) + N2W'(p1[k])) * 2 + N2W'(den_d);
            neg_ff[k] <= n2[N2W-1];
            mag_ff[k] <= n2[N2W-1] ? N2W'(unsigned'(-n2)) : N2W'(unsigned'(n2));
         end
         dvs_ff <= {den_d, 1'b0};
      end
   end

   // Output register: floor correction for negatives, then add A.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            logic [QB:0] qu;
            logic [QB:0] qs;
            qu = {1'b0, qmag[k]} + (QB+1)'(rnz[k]);
            qs = qneg[k] ? -qu : {1'b0, qmag[k]};
            out_ff[k] <= degen_t ? W'(va_t[k]) : W'(va_t[k]) + qs[W-1:0];
         end
      end
   end

   assign rsp_tdata = RSP_TDW'({out_ff[2], out_ff[1], out_ff[0]});

   `CPT_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid, "result valid after reset")
   `CPT_ASSERT(a_degen_vertex, clock, reset, en && v_ff[LAT-2] && degen_t |=> rsp_tdata[W-1:0] == $past(W'(va_t[0])), "degenerate triangle must return vertex A")
   `CPT_ASSERT(a_quot_bound, clock, reset, v_ff[LAT-2] && !degen_t |-> qmag[0] <= QMAX && qmag[1] <= QMAX && qmag[2] <= QMAX, "quotient outside the triangle bound")

endmodule

FILE: tb/closest_point_on_triangle_checker.sv
// Response checker for closest_point_on_triangle: predicts each closest point
// with exact wide integer arithmetic and compares it with what the unit returns.
// Depends on cpt_pkg for the coordinate width.
module closest_point_on_triangle_checker import cpt_pkg::*; #(
   parameter int CW = COORD_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [12*CW-1:0]      req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [3*CW-1:0]       rsp_tdata,
   output int                    error_count,
   output int                    pending_count
);

   typedef logic signed [287:0] wide_t;

   logic [3*CW-1:0] expected_points[$];

   function automatic wide_t dot3(input wide_t x[3], input wide_t y[3]);
      return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
   endfunction

   // Exact closest point: s and t stay as fractions sn/den, tn/den until the
   // final per-coordinate rounding (half rounds up).
   function automatic logic [3*CW-1:0] nearest_point(input logic [12*CW-1:0] d);
      wide_t p[3], va[3], e0[3], e1[3], dv[3];
      wide_t a, b, c, de, ee, det, s, t, sn, tn, den, m, t0, t1, num, n2, dd, q;
      logic [3*CW-1:0] r;
      for (int k = 0; k < 3; k++) begin
         p[k]  = wide_t'($signed(d[CW*k +: CW]));
         va[k] = wide_t'($signed(d[CW*(3+k) +: CW]));
         e0[k] = wide_t'($signed(d[CW*(6+k) +: CW])) - va[k];
         e1[k] = wide_t'($signed(d[CW*(9+k) +: CW])) - va[k];
         dv[k] = va[k] - p[k];
      end
      a = dot3(e0, e0); b = dot3(e0, e1); c = dot3(e1, e1);
      de = dot3(e0, dv); ee = dot3(e1, dv);
      det = a * c - b * b;
      s = b * ee - c * de;
      t = b * de - a * ee;
      sn = 0; tn = 0; den = 1;
      if (det <= 0) begin
         for (int k = 0; k < 3; k++) r[CW*k +: CW] = va[k][CW-1:0];
         return r;
      end
      if (s + t <= det) begin
         if (s < 0) begin
            if (t < 0) begin
               // Vertex A region: the e test comes first.
               if (ee < 0) begin
                  if (-ee >= c) begin tn = 1; den = 1; end else begin tn = -ee; den = c; end
               end else if (de < 0) begin
                  if (-de >= a) begin sn = 1; den = 1; end else begin sn = -de; den = a; end
               end
            end else if (ee < 0) begin
               if (-ee >= c) begin tn = 1; den = 1; end else begin tn = -ee; den = c; end
            end
         end else if (t < 0) begin
            if (de < 0) begin
               if (-de >= a) begin sn = 1; den = 1; end else begin sn = -de; den = a; end
            end
         end else begin
            sn = s; tn = t; den = det;
         end
      end else begin
         m = a + c - (b + b);
         if (s < 0) begin
            t0 = b + de; t1 = c + ee;
            if (t1 > t0) begin
               if (t1 - t0 >= m) begin sn = 1; tn = 0; den = 1; end
               else begin sn = t1 - t0; tn = m - (t1 - t0); den = m; end
            end else if (t1 <= 0) tn = 1;
            else if (ee < 0) begin tn = -ee; den = c; end
         end else if (t < 0) begin
            t0 = b + ee; t1 = a + de;
            if (t1 > t0) begin
               if (t1 - t0 >= m) begin tn = 1; sn = 0; den = 1; end
               else begin tn = t1 - t0; sn = m - (t1 - t0); den = m; end
            end else if (t1 <= 0) sn = 1;
            else if (de < 0) begin sn = -de; den = a; end
         end else begin
            num = (c + ee) - (b + de);
            if (num <= 0) tn = 1;
            else if (num >= m) begin sn = 1; tn = 0; den = 1; end
            else begin sn = num; tn = m - num; den = m; end
         end
      end
      for (int k = 0; k < 3; k++) begin
         num = e0[k] * sn + e1[k] * tn;
         n2 = num + num + den;
         dd = den + den;
         q = n2 / dd;
         if (n2 % dd != 0 && n2 < 0) q = q - 1;
         r[CW*k +: CW] = va[k][CW-1:0] + q[CW-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      error_count++;
   endtask

   assign pending_count = expected_points.size();

   initial error_count = 0;

   always @(posedge clock) begin
      logic [3*CW-1:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_points.push_back(nearest_point(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               report_mismatch($sformatf("unexpected item %h", rsp_tdata));
            end else begin
               want = expected_points.pop_front();
               for (int k = 0; k < 3; k++)
                  if (rsp_tdata[CW*k +: CW] !== want[CW*k +: CW])
                     report_mismatch($sformatf("coordinate %0d got %h want %h",
                        k, rsp_tdata[CW*k +: CW], want[CW*k +: CW]));
            end
         end
      end
   end

endmodule

FILE: tb/closest_point_on_triangle_tb.sv
// Top of the closest_point_on_triangle testbench: clock, reset, stimulus,
// handshake pacing and the verdict. Depends on cpt_pkg, the checker and the RTL.
module closest_point_on_triangle_tb import cpt_pkg::*;;

   localparam int CW = COORD_WIDTH_DEF;
   localparam int ONE = 1 << 16;            // 1.0 in Q16.16
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 1230;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [12*CW-1:0]  req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [3*CW-1:0]   rsp_tdata;
   int                error_count;
   int                pending_count;
   int                idle_pct;
   int                stall_pct;
   int                cycle_count;

   closest_point_on_triangle dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   closest_point_on_triangle_checker #(.CW(CW)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .error_count(error_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // The receiver stalls at the rate the current phase asks for.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: a hung pipeline or a lost item ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("closest_point_on_triangle_tb: errors");
         $finish;
      end
   end

   // Presents one item and holds it until the unit accepts it. The sender
   // may idle first, with req_tvalid low, at the phase's rate.
   task automatic send_item(input logic [12*CW-1:0] item);
      if ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
   endtask

   // Packs P, A, B, C with point_x in the lowest bits.
   function automatic logic [12*CW-1:0] pack_query(
      input int px, py, pz, ax, ay, az, bx, by, bz, cx, cy, cz);
      return {cz, cy, cx, bz, by, bx, az, ay, ax, pz, py, px};
   endfunction

   // Coordinate from a small span, so that all seven regions come up often.
   function automatic int near_coord();
      return $urandom_range(8 * ONE) - 4 * ONE;
   endfunction

   function automatic logic [12*CW-1:0] random_query();
      logic [12*CW-1:0] q;
      int sel;
      sel = $urandom_range(99);
      for (int k = 0; k < 12; k++) begin
         if (sel < 20) q[CW*k +: CW] = $urandom();
         else if (sel < 30) q[CW*k +: CW] = $urandom_range(15) - 8;
         else q[CW*k +: CW] = near_coord();
      end
      // Some triangles are made degenerate: B or C coincides with A, or C
      // lies on the line through A and B.
      if (sel >= 90 && sel < 94) q[CW*6 +: 3*CW] = q[CW*3 +: 3*CW];
      if (sel >= 94 && sel < 97) q[CW*9 +: 3*CW] = q[CW*3 +: 3*CW];
      if (sel >= 97)
         for (int k = 0; k < 3; k++)
            q[CW*(9+k) +: CW] = 2 * q[CW*(6+k) +: CW] - q[CW*(3+k) +: CW];
      return q;
   endfunction

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int lo, hi;
      lo = 32'h8000_0000;
      hi = 32'h7fff_ffff;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      cycle_count = 0;
      idle_pct = 0;
      stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed items: first the unit triangle A=0, B=x, C=y with one point per
      // region, then other small, degenerate and extreme triangles.
      send_item(pack_query(ONE/4, ONE/4, ONE, 0,0,0, ONE,0,0, 0,ONE,0));
      send_item(pack_query(-ONE, -ONE, 0, 0,0,0, ONE,0,0, 0,ONE,0));
      send_item(pack_query(-ONE, ONE/2, 0, 0,0,0, ONE,0,0, 0,ONE,0));
      send_item(pack_query(ONE/2, -ONE, 0, 0,0,0, ONE,0,0, 0,ONE,0));
      send_item(pack_query(ONE, ONE, 3, 0,0,0, ONE,0,0, 0,ONE,0));
      send_item(pack_query(2*ONE, -ONE/2, 0, 0,0,0, ONE,0,0, 0,ONE,0));
      send_item(pack_query(-ONE/2, 2*ONE, 0, 0,0,0, ONE,0,0, 0,ONE,0));
      send_item(pack_query(-ONE, 3*ONE, 0, 0,0,0, ONE,0,0, 0,ONE,0));
      send_item(pack_query(3*ONE, -ONE, 0, 0,0,0, ONE,0,0, 0,ONE,0));
      // Point on the far side of A with e and d both positive.
      send_item(pack_query(-5, -7, 1, 0,0,0, 3,0,0, 0,7,0));
      // Small triangles with legs of three and of one.
      send_item(pack_query(1, 1, 0, 0,0,0, 3,0,0, 0,3,0));
      send_item(pack_query(2, 5, 1, 0,0,0, 1,0,0, 0,1,0));
      // Degenerate: all three vertices equal, then collinear vertices.
      send_item(pack_query(ONE, 2*ONE, 3*ONE, 5,6,7, 5,6,7, 5,6,7));
      send_item(pack_query(ONE, ONE, 0, 0,0,0, ONE,ONE,ONE, 2*ONE,2*ONE,2*ONE));
      // Extreme coordinates.
      send_item(pack_query(hi,hi,hi, lo,lo,lo, hi,lo,lo, lo,hi,lo));
      send_item(pack_query(lo,lo,lo, hi,hi,hi, lo,hi,hi, hi,lo,hi));
      send_item(pack_query(hi,lo,hi, lo,lo,lo, hi,hi,hi, lo,hi,hi));
      send_item(pack_query(0,0,0, hi,lo,0, lo,hi,0, hi,hi,hi));
      send_item(pack_query(-1,-1,-1, -1,-1,-1, 0,0,0, -1,0,-1));
      send_item(pack_query(lo,hi,lo, hi,lo,hi, hi,lo,lo, lo,lo,hi));

      // The sender waits here for every result before the random part.
      drain();

      // Four pacing phases: none, sender idling, receiver stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct  = (phase == 1) ? 57 : (phase == 3) ? 25 : 0;
         stall_pct = (phase == 2) ? 57 : (phase == 3) ? 25 : 0;
         for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
            // Occasional bursts with no idling at all.
            if (n % 100 == 50) idle_pct = 0;
            if (n % 100 == 70) idle_pct = (phase == 1) ? 57 : (phase == 3) ? 25 : 0;
            send_item(random_query());
         end
      end

      drain();
      stall_pct = 0;
      repeat (60) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("closest_point_on_triangle_tb: clean");
      end else begin
         $display("closest_point_on_triangle_tb: errors");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+src
src/cpt_pkg.sv
src/cpt_dly.sv
src/cpt_mul.sv
src/cpt_region.sv
src/cpt_div.sv
src/closest_point_on_triangle.sv
tb/closest_point_on_triangle_checker.sv
tb/closest_point_on_triangle_tb.sv
